### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Constants, codes and the controller/datapath command and status types of
// the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   // Pool geometry
   localparam int MIN_BLOCK_BYTES = 128;
   localparam int TOP_ORDER       = 10;
   localparam int TOP_BLOCKS      = 32;
   localparam int HEADER_BYTES    = 40;
   localparam int POOL_UNITS      = TOP_BLOCKS << TOP_ORDER;

   // Field widths
   localparam int IDX_W      = 15;
   localparam int ORD_W      = 4;
   localparam int BYTES_W    = 27;
   localparam int TOTAL_W    = BYTES_W + 1;
   localparam int CNT_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 1;

   // Register reset values
   localparam logic [BYTES_W-1:0] MAX_REQ_RESET = BYTES_W'(100000000);
   localparam logic [BYTES_W-1:0] HUGE_RESET    = BYTES_W'(4 * 1024 * 1024);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_REQ = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HUGE    = 1'b1;

   // Request types
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_FREE   = 2'd1;
   localparam logic [1:0] REQ_RESIZE = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXT      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HUGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADSIZE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTBLOCK = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FREED    = 3'd6;

   // Table read address select
   localparam logic [1:0] RD_BIDX = 2'd0;
   localparam logic [1:0] RD_BUD  = 2'd1;
   localparam logic [1:0] RD_CUR  = 2'd2;

   // Table write select
   localparam logic [2:0] WR_NONE      = 3'd0;
   localparam logic [2:0] WR_CLEAR     = 3'd1;
   localparam logic [2:0] WR_ZERO_MAX  = 3'd2;
   localparam logic [2:0] WR_FREE_HEAD = 3'd3;
   localparam logic [2:0] WR_USED_HEAD = 3'd4;
   localparam logic [2:0] WR_SPLIT     = 3'd5;

   // Walking index update
   localparam logic [2:0] CUR_HOLD = 3'd0;
   localparam logic [2:0] CUR_BIDX = 3'd1;
   localparam logic [2:0] CUR_MIN  = 3'd2;
   localparam logic [2:0] CUR_ZERO = 3'd3;
   localparam logic [2:0] CUR_BEST = 3'd4;
   localparam logic [2:0] CUR_NEXT = 3'd5;

   // Walking order update
   localparam logic [2:0] ORD_HOLD  = 3'd0;
   localparam logic [2:0] ORD_ENTRY = 3'd1;
   localparam logic [2:0] ORD_INC   = 3'd2;
   localparam logic [2:0] ORD_DEC   = 3'd3;
   localparam logic [2:0] ORD_BEST  = 3'd4;
   localparam logic [2:0] ORD_HEAD  = 3'd5;

   // Block counter update
   localparam logic [2:0] CNT_HOLD    = 3'd0;
   localparam logic [2:0] CNT_TAKE    = 3'd1;
   localparam logic [2:0] CNT_SPLIT   = 3'd2;
   localparam logic [2:0] CNT_MERGE   = 3'd3;
   localparam logic [2:0] CNT_RELEASE = 3'd4;

   // Response register update
   localparam logic [1:0] RES_HOLD  = 2'd0;
   localparam logic [1:0] RES_CODE  = 2'd1;
   localparam logic [1:0] RES_KEEP  = 2'd2;
   localparam logic [1:0] RES_GRANT = 2'd3;

   // One table entry
   typedef struct packed {
      logic             head;
      logic             free;
      logic [ORD_W-1:0] ord;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic                latch;
      logic [1:0]          rd_sel;
      logic [2:0]          wr_sel;
      logic [2:0]          cur_op;
      logic [2:0]          ord_op;
      logic [2:0]          cnt_op;
      logic                scan_init;
      logic                scan_eval;
      logic [1:0]          res_op;
      logic [STATUS_W-1:0] res_status;
      logic                res_moved;
      logic                respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       clr_last;
      logic       bad_size;
      logic       huge;
      logic       no_fit;
      logic       oob;
      logic       ent_head;
      logic       ent_free;
      logic       fits_ent;
      logic       ord_lt_top;
      logic       ord_lt_tgt;
      logic       ord_gt_tgt;
      logic       bud_free;
      logic       scan_hit;
      logic       scan_end;
      logic       have_best;
   } sts_type;

endpackage

`default_nettype wire

### rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Block table memory, request and config registers, walking index/order,
// scan tracking, block counters and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [1:0]                       req_type,
   input  wire logic [bba_pkg::BYTES_W-1:0]      req_size_bytes,
   input  wire logic [bba_pkg::IDX_W-1:0]        req_block_index,
   input  wire logic                             csr_we,
   input  wire logic [bba_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [bba_pkg::BYTES_W-1:0]      csr_wdata,
   input  wire bba_pkg::cmd_type                 cmd,
   output bba_pkg::sts_type                      sts,
   output logic                                  rsp_valid,
   output logic [bba_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bba_pkg::IDX_W-1:0]             rsp_result_index,
   output logic [bba_pkg::ORD_W-1:0]             rsp_result_order,
   output logic                                  rsp_moved,
   output logic [bba_pkg::CNT_W-1:0]             rsp_free_blocks,
   output logic [bba_pkg::CNT_W-1:0]             rsp_pool_blocks
);
   import bba_pkg::*;

   // Smallest order whose span holds total bytes; top bit set when none does
   function automatic logic [ORD_W:0] fit_order(input logic [TOTAL_W-1:0] total);
      logic [ORD_W:0] fit;
      fit = {1'b1, {ORD_W{1'b0}}};
      for (int o = TOP_ORDER; o >= 0; o--) begin
         if (64'(total) <= (64'(MIN_BLOCK_BYTES) << o)) begin
            fit = {1'b0, ORD_W'(o)};
         end
      end
      return fit;
   endfunction

   entry_type mem [POOL_UNITS];
   entry_type rdata_ff;

   logic [1:0]          type_ff, type_in;
   logic [BYTES_W-1:0]  size_ff, size_in;
   logic [IDX_W-1:0]    bidx_ff, bidx_in;
   logic [BYTES_W-1:0]  max_ff, max_in;
   logic [BYTES_W-1:0]  huge_ff, huge_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [ORD_W-1:0]    head_ord_ff, head_ord_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [ORD_W-1:0]    best_ord_ff, best_ord_in;
   logic                have_ff, have_in;
   logic [CNT_W-1:0]    free_ff, free_in;
   logic [CNT_W-1:0]    block_ff, block_in;
   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;
   logic [ORD_W-1:0]    rord_ff, rord_in;
   logic                moved_ff, moved_in;

   logic [TOTAL_W-1:0]  total;
   logic [ORD_W:0]      fit;
   logic [ORD_W-1:0]    tgt;
   logic [IDX_W-1:0]    bit_o;
   logic [IDX_W-1:0]    bud;
   logic [IDX_W-1:0]    cur_min;
   logic [IDX_W-1:0]    bud_max;
   logic [ORD_W-1:0]    ord_dn;
   logic [IDX_W-1:0]    split_addr;
   logic                k_ge;
   logic                scan_cand;
   logic [IDX_W:0]      scan_step;
   logic [IDX_W:0]      scan_next;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   // Size and geometry helpers
   assign total      = TOTAL_W'(size_ff) + TOTAL_W'(HEADER_BYTES);
   assign fit        = fit_order(total);
   assign tgt        = fit[ORD_W-1:0];
   assign bit_o      = IDX_W'(1) << ord_ff;
   assign bud        = cur_ff ^ bit_o;
   assign cur_min    = cur_ff & ~bit_o;
   assign bud_max    = cur_ff | bit_o;
   assign ord_dn     = ord_ff - 1'b1;
   assign split_addr = cur_ff + (IDX_W'(1) << ord_dn);

   // Scan step: jump over big blocks, step by the target span otherwise
   assign k_ge      = rdata_ff.ord >= tgt;
   assign scan_cand = rdata_ff.head && rdata_ff.free && k_ge &&
                      (!have_ff || (rdata_ff.ord < best_ord_ff));
   assign scan_step = (IDX_W+1)'(1) << (k_ge ? rdata_ff.ord : tgt);
   assign scan_next = {1'b0, cur_ff} + scan_step;

   // Status to controller
   always_comb begin
      sts.req_type   = type_ff;
      sts.clr_last   = clr_ff == IDX_W'(POOL_UNITS - 1);
      sts.bad_size   = (size_ff == '0) || (size_ff > max_ff);
      sts.huge       = size_ff >= huge_ff;
      sts.no_fit     = fit[ORD_W];
      sts.oob        = {1'b0, bidx_ff} >= (IDX_W+1)'(POOL_UNITS);
      sts.ent_head   = rdata_ff.head;
      sts.ent_free   = rdata_ff.free;
      sts.fits_ent   = 64'(total) <= (64'(MIN_BLOCK_BYTES) << rdata_ff.ord);
      sts.ord_lt_top = ord_ff < ORD_W'(TOP_ORDER);
      sts.ord_lt_tgt = ord_ff < tgt;
      sts.ord_gt_tgt = ord_ff > tgt;
      sts.bud_free   = rdata_ff.head && rdata_ff.free && (rdata_ff.ord == ord_ff);
      sts.scan_hit   = scan_cand && (rdata_ff.ord == tgt);
      sts.scan_end   = scan_next >= (IDX_W+1)'(POOL_UNITS);
      sts.have_best  = have_ff;
   end

   // Table read address
   always_comb begin
      case (cmd.rd_sel)
         RD_BIDX: mem_raddr = bidx_ff;
         RD_BUD:  mem_raddr = bud;
         RD_CUR:  mem_raddr = cur_ff;
         default: mem_raddr = bidx_ff;
      endcase
   end

   // Table write port
   always_comb begin
      mem_we    = 1'b1;
      mem_waddr = cur_ff;
      mem_wdata = '0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            mem_waddr = clr_ff;
            if (clr_ff[TOP_ORDER-1:0] == '0) begin
               mem_wdata = '{head: 1'b1, free: 1'b1, ord: ORD_W'(TOP_ORDER)};
            end
         end
         WR_ZERO_MAX: begin
            mem_waddr = bud_max;
         end
         WR_FREE_HEAD: begin
            mem_wdata = '{head: 1'b1, free: 1'b1, ord: ord_ff};
         end
         WR_USED_HEAD: begin
            mem_wdata = '{head: 1'b1, free: 1'b0, ord: tgt};
         end
         WR_SPLIT: begin
            mem_waddr = split_addr;
            mem_wdata = '{head: 1'b1, free: 1'b1, ord: ord_dn};
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Block table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // Request capture and config registers
   always_comb begin
      type_in = type_ff;
      size_in = size_ff;
      bidx_in = bidx_ff;
      max_in  = max_ff;
      huge_in = huge_ff;
      if (cmd.latch) begin
         type_in = req_type;
         size_in = req_size_bytes;
         bidx_in = req_block_index;
      end
      if (csr_we) begin
         case (csr_addr)
            CSR_MAX_REQ: max_in  = csr_wdata;
            CSR_HUGE:    huge_in = csr_wdata;
            default:     max_in  = max_ff;
         endcase
      end
   end

   // Walking index, order and scan best
   always_comb begin
      clr_in      = (cmd.wr_sel == WR_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      cur_in      = cur_ff;
      ord_in      = ord_ff;
      head_ord_in = head_ord_ff;
      best_in     = best_ff;
      best_ord_in = best_ord_ff;
      have_in     = have_ff;
      case (cmd.cur_op)
         CUR_BIDX: cur_in = bidx_ff;
         CUR_MIN:  cur_in = cur_min;
         CUR_ZERO: cur_in = '0;
         CUR_BEST: cur_in = best_ff;
         CUR_NEXT: cur_in = scan_next[IDX_W-1:0];
         default:  cur_in = cur_ff;
      endcase
      case (cmd.ord_op)
         ORD_ENTRY: begin
            ord_in      = rdata_ff.ord;
            head_ord_in = rdata_ff.ord;
         end
         ORD_INC:  ord_in = ord_ff + 1'b1;
         ORD_DEC:  ord_in = ord_dn;
         ORD_BEST: ord_in = best_ord_ff;
         ORD_HEAD: ord_in = head_ord_ff;
         default:  ord_in = ord_ff;
      endcase
      if (cmd.scan_init) begin
         have_in = 1'b0;
      end
      if (cmd.scan_eval && scan_cand) begin
         have_in     = 1'b1;
         best_in     = cur_ff;
         best_ord_in = rdata_ff.ord;
      end
   end

   // Free and pool block counters
   always_comb begin
      free_in  = free_ff;
      block_in = block_ff;
      case (cmd.cnt_op)
         CNT_TAKE: free_in = free_ff - 1'b1;
         CNT_SPLIT: begin
            free_in  = free_ff + 1'b1;
            block_in = block_ff + 1'b1;
         end
         CNT_MERGE: begin
            free_in  = free_ff - 1'b1;
            block_in = block_ff - 1'b1;
         end
         CNT_RELEASE: free_in = free_ff + 1'b1;
         default: free_in = free_ff;
      endcase
   end

   // Response registers
   always_comb begin
      valid_in  = cmd.respond;
      status_in = status_ff;
      ridx_in   = ridx_ff;
      rord_in   = rord_ff;
      moved_in  = moved_ff;
      case (cmd.res_op)
         RES_CODE: begin
            status_in = cmd.res_status;
            ridx_in   = '0;
            rord_in   = '0;
            moved_in  = cmd.res_moved;
         end
         RES_KEEP: begin
            status_in = ST_OK;
            ridx_in   = bidx_ff;
            rord_in   = rdata_ff.ord;
            moved_in  = 1'b0;
         end
         RES_GRANT: begin
            status_in = ST_OK;
            ridx_in   = cur_ff;
            rord_in   = tgt;
            moved_in  = (type_ff == REQ_RESIZE) && (cur_ff != bidx_ff);
         end
         default: status_in = status_ff;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_REQ_RESET;
         huge_ff  <= HUGE_RESET;
         clr_ff   <= '0;
         have_ff  <= 1'b0;
         free_ff  <= CNT_W'(TOP_BLOCKS);
         block_ff <= CNT_W'(TOP_BLOCKS);
         valid_ff <= 1'b0;
      end else begin
         max_ff   <= max_in;
         huge_ff  <= huge_in;
         clr_ff   <= clr_in;
         have_ff  <= have_in;
         free_ff  <= free_in;
         block_ff <= block_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      size_ff     <= size_in;
      bidx_ff     <= bidx_in;
      cur_ff      <= cur_in;
      ord_ff      <= ord_in;
      head_ord_ff <= head_ord_in;
      best_ff     <= best_in;
      best_ord_ff <= best_ord_in;
      status_ff   <= status_in;
      ridx_ff     <= ridx_in;
      rord_ff     <= rord_in;
      moved_ff    <= moved_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_index = ridx_ff;
   assign rsp_result_order = rord_ff;
   assign rsp_moved        = moved_ff;
   assign rsp_free_blocks  = free_ff;
   assign rsp_pool_blocks  = block_ff;

endmodule

`default_nettype wire

### rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: clearing pass, decode, scan, split, merge and grow
// steps, issued to the datapath as commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire bba_pkg::sts_type sts,
   output bba_pkg::cmd_type      cmd,
   output logic                  busy
);
   import bba_pkg::*;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DECODE   = 4'd2;
   localparam logic [3:0] S_HEAD     = 4'd3;
   localparam logic [3:0] S_MRG_RD   = 4'd4;
   localparam logic [3:0] S_MRG_EV   = 4'd5;
   localparam logic [3:0] S_MRG_FIN  = 4'd6;
   localparam logic [3:0] S_CHK_RD   = 4'd7;
   localparam logic [3:0] S_CHK_EV   = 4'd8;
   localparam logic [3:0] S_GROW     = 4'd9;
   localparam logic [3:0] S_SCAN_RD  = 4'd10;
   localparam logic [3:0] S_SCAN_EV  = 4'd11;
   localparam logic [3:0] S_SCAN_END = 4'd12;
   localparam logic [3:0] S_SPLIT    = 4'd13;

   logic [3:0] state_ff, state_in;

   assign busy = state_ff != S_IDLE;

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.rd_sel = RD_BIDX;
            case (sts.req_type)
               REQ_ALLOC: begin
                  if (sts.bad_size || sts.huge || sts.no_fit) begin
                     cmd.res_op     = RES_CODE;
                     cmd.res_status = sts.bad_size ? ST_BADSIZE :
                                      sts.huge     ? ST_HUGE : ST_EXT;
                     cmd.respond    = 1'b1;
                     state_in       = S_IDLE;
                  end else begin
                     cmd.scan_init = 1'b1;
                     cmd.cur_op    = CUR_ZERO;
                     state_in      = S_SCAN_RD;
                  end
               end
               REQ_FREE: begin
                  state_in = S_HEAD;
               end
               REQ_RESIZE: begin
                  if (sts.bad_size) begin
                     cmd.res_op     = RES_CODE;
                     cmd.res_status = ST_BADSIZE;
                     cmd.respond    = 1'b1;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
               default: begin
                  cmd.res_op     = RES_CODE;
                  cmd.res_status = ST_BADSIZE;
                  cmd.respond    = 1'b1;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_HEAD: begin
            if (sts.oob || !sts.ent_head || sts.ent_free) begin
               cmd.res_op     = RES_CODE;
               cmd.res_status = (sts.oob || !sts.ent_head) ? ST_NOTBLOCK : ST_FREED;
               cmd.respond    = 1'b1;
               state_in       = S_IDLE;
            end else if (sts.req_type == REQ_FREE) begin
               cmd.res_op     = RES_CODE;
               cmd.res_status = ST_OK;
               cmd.cur_op     = CUR_BIDX;
               cmd.ord_op     = ORD_ENTRY;
               state_in       = S_MRG_RD;
            end else if (sts.fits_ent) begin
               cmd.res_op  = RES_KEEP;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else if (sts.no_fit) begin
               cmd.res_op     = RES_CODE;
               cmd.res_status = ST_NOSPACE;
               cmd.respond    = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.cur_op = CUR_BIDX;
               cmd.ord_op = ORD_ENTRY;
               state_in   = S_CHK_RD;
            end
         end
         // Merge the freed block upward while its buddy is free
         S_MRG_RD: begin
            cmd.rd_sel = RD_BUD;
            state_in   = sts.ord_lt_top ? S_MRG_EV : S_MRG_FIN;
         end
         S_MRG_EV: begin
            if (sts.bud_free) begin
               cmd.wr_sel = WR_ZERO_MAX;
               cmd.cur_op = CUR_MIN;
               cmd.ord_op = ORD_INC;
               cmd.cnt_op = CNT_MERGE;
               state_in   = S_MRG_RD;
            end else begin
               state_in = S_MRG_FIN;
            end
         end
         S_MRG_FIN: begin
            cmd.wr_sel  = WR_FREE_HEAD;
            cmd.cnt_op  = CNT_RELEASE;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         // Check the buddy chain for growth in place
         S_CHK_RD: begin
            cmd.rd_sel = RD_BUD;
            if (sts.ord_lt_tgt) begin
               state_in = S_CHK_EV;
            end else begin
               cmd.cur_op = CUR_BIDX;
               cmd.ord_op = ORD_HEAD;
               state_in   = S_GROW;
            end
         end
         S_CHK_EV: begin
            if (sts.bud_free) begin
               cmd.cur_op = CUR_MIN;
               cmd.ord_op = ORD_INC;
               state_in   = S_CHK_RD;
            end else if (sts.huge) begin
               cmd.res_op     = RES_CODE;
               cmd.res_status = ST_HUGE;
               cmd.res_moved  = 1'b1;
               cmd.cur_op     = CUR_BIDX;
               cmd.ord_op     = ORD_HEAD;
               state_in       = S_MRG_RD;
            end else begin
               cmd.scan_init = 1'b1;
               cmd.cur_op    = CUR_ZERO;
               state_in      = S_SCAN_RD;
            end
         end
         // Absorb the buddy chain, then write the grown head
         S_GROW: begin
            if (sts.ord_lt_tgt) begin
               cmd.wr_sel = WR_ZERO_MAX;
               cmd.cur_op = CUR_MIN;
               cmd.ord_op = ORD_INC;
               cmd.cnt_op = CNT_MERGE;
            end else begin
               cmd.wr_sel  = WR_USED_HEAD;
               cmd.res_op  = RES_GRANT;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         // Walk blocks in address order for the best free fit
         S_SCAN_RD: begin
            cmd.rd_sel = RD_CUR;
            state_in   = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            if (sts.scan_hit || sts.scan_end) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.cur_op = CUR_NEXT;
               state_in   = S_SCAN_RD;
            end
         end
         S_SCAN_END: begin
            if (!sts.have_best) begin
               cmd.res_op     = RES_CODE;
               cmd.res_status = ST_NOSPACE;
               cmd.respond    = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.cur_op = CUR_BEST;
               cmd.ord_op = ORD_BEST;
               cmd.cnt_op = CNT_TAKE;
               state_in   = S_SPLIT;
            end
         end
         // Split down to the target order, leaving upper halves free
         S_SPLIT: begin
            if (sts.ord_gt_tgt) begin
               cmd.wr_sel = WR_SPLIT;
               cmd.ord_op = ORD_DEC;
               cmd.cnt_op = CNT_SPLIT;
            end else begin
               cmd.wr_sel = WR_USED_HEAD;
               cmd.res_op = RES_GRANT;
               if (sts.req_type == REQ_RESIZE) begin
                  cmd.cur_op = CUR_BIDX;
                  cmd.ord_op = ORD_HEAD;
                  state_in   = S_MRG_RD;
               end else begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/buddy_block_allocator_top.sv
// Requests are served one at a time. Bad size and unknown requests are answered
// at decode, block checks at the table read; free merges with free buddies up to
// the top order; allocate scans blocks in address order up to the first exact fit,
// then splits; resize checks the buddy chain and, when it moves, adds the free of
// the old block. Reset: a clearing pass over all 32768 table entries rebuilds the
// block table, busy high.
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator over 32 top blocks of order 10 with 128-byte units.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_type,
   input  wire logic [bba_pkg::BYTES_W-1:0]    req_size_bytes,
   input  wire logic [bba_pkg::IDX_W-1:0]      req_block_index,
   input  wire logic                           csr_we,
   input  wire logic [bba_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [bba_pkg::BYTES_W-1:0]    csr_wdata,
   output logic                                rsp_valid,
   output logic [bba_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bba_pkg::IDX_W-1:0]           rsp_result_index,
   output logic [bba_pkg::ORD_W-1:0]           rsp_result_order,
   output logic                                rsp_moved,
   output logic [bba_pkg::CNT_W-1:0]           rsp_free_blocks,
   output logic [bba_pkg::CNT_W-1:0]           rsp_pool_blocks
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer
   bba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Table, counters and response registers
   bba_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_size_bytes   (req_size_bytes),
      .req_block_index  (req_block_index),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_result_order (rsp_result_order),
      .rsp_moved        (rsp_moved),
      .rsp_free_blocks  (rsp_free_blocks),
      .rsp_pool_blocks  (rsp_pool_blocks)
   );

endmodule

`default_nettype wire

### rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks on request acceptance and response contents.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bba_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic [bba_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [bba_pkg::IDX_W-1:0]    rsp_result_index,
   input wire logic [bba_pkg::ORD_W-1:0]    rsp_result_order,
   input wire logic [bba_pkg::CNT_W-1:0]    rsp_free_blocks,
   input wire logic [bba_pkg::CNT_W-1:0]    rsp_pool_blocks
);
   import bba_pkg::*;

   // An accepted request keeps the block busy on the next cycle
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // One strobe per request, never two in a row
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // Only a successful grant reports a block
   `ASSERT_SAME(a_fail_no_block, clock, reset, rsp_valid && (rsp_status != ST_OK), (rsp_result_index == '0) && (rsp_result_order == '0))
   // Free blocks never exceed all blocks
   `ASSERT_SAME(a_free_le_pool, clock, reset, rsp_valid, rsp_free_blocks <= rsp_pool_blocks)

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);

`default_nettype wire

### test/buddy_block_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_top_tb
// Drives allocate, free and resize requests into the buddy allocator and
// checks every response field against a behavioral copy of the pool kept in
// the bench. A directed table comes first, then random traffic over several
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_top_tb;
   import bba_pkg::*;

   localparam logic [5:0] UNIT_HEAD = 6'h20;
   localparam logic [5:0] UNIT_FREE = 6'h10;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int ITEMS_PER_PHASE = 170;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [ORD_W-1:0]    order;
      logic                moved;
      logic [CNT_W-1:0]    free_blocks;
      logic [CNT_W-1:0]    pool_blocks;
   } grant_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTES_W-1:0] size;
      logic [IDX_W-1:0]   bidx;
      logic               typed;
      grant_type          want;
   } row_type;

   logic                  clock, reset, start, busy;
   logic [1:0]            req_type;
   logic [BYTES_W-1:0]    req_size_bytes;
   logic [IDX_W-1:0]      req_block_index;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [BYTES_W-1:0]    csr_wdata;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [IDX_W-1:0]      rsp_result_index;
   logic [ORD_W-1:0]      rsp_result_order;
   logic                  rsp_moved;
   logic [CNT_W-1:0]      rsp_free_blocks;
   logic [CNT_W-1:0]      rsp_pool_blocks;

   // shadow pool state
   logic [5:0]         pool_map [POOL_UNITS];
   int unsigned        free_total, block_total;
   logic [BYTES_W-1:0] max_request, huge_limit;

   grant_type pending_grants [$];
   row_type   directed [$];
   int        used_heads [$];
   int        mismatches;

   buddy_block_allocator_top uut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int order_for(logic [BYTES_W:0] total);
      for (int o = 0; o <= TOP_ORDER; o++)
         if (total <= (MIN_BLOCK_BYTES << o)) return o;
      return -1;
   endfunction

   // carve the lowest free block of the smallest fitting order
   task automatic carve(input logic [BYTES_W-1:0] size, output logic [2:0] st,
                        output int at, output int ord);
      int target, o, i, hit_at, hit_ord;
      bit hit;
      at = 0; ord = 0; hit = 0; hit_at = 0; hit_ord = 0;
      if (size == 0 || size > max_request) begin
         st = ST_BADSIZE; return;
      end
      if (size >= huge_limit) begin
         st = ST_HUGE; return;
      end
      target = order_for((BYTES_W+1)'({1'b0, size} + HEADER_BYTES));
      if (target < 0) begin
         st = ST_EXT; return;
      end
      for (o = target; o <= TOP_ORDER && !hit; o++)
         for (i = 0; i < POOL_UNITS; i += (1 << o))
            if (pool_map[i] == (UNIT_HEAD | UNIT_FREE | 6'(o))) begin
               hit = 1; hit_at = i; hit_ord = o; break;
            end
      if (!hit) begin
         st = ST_NOSPACE; return;
      end
      free_total--;
      while (hit_ord > target) begin
         hit_ord--;
         pool_map[hit_at + (1 << hit_ord)] = UNIT_HEAD | UNIT_FREE | 6'(hit_ord);
         free_total++;
         block_total++;
      end
      pool_map[hit_at] = UNIT_HEAD | 6'(target);
      st = ST_OK; at = hit_at; ord = target;
   endtask

   // release a used block and merge upward with free buddies
   task automatic release_block(input int at);
      int o, cur, bud;
      o = pool_map[at][3:0];
      cur = at;
      while (o < TOP_ORDER) begin
         bud = cur ^ (1 << o);
         if (pool_map[bud] != (UNIT_HEAD | UNIT_FREE | 6'(o))) break;
         pool_map[bud] = '0;
         pool_map[cur] = '0;
         if (bud < cur) cur = bud;
         free_total--;
         block_total--;
         o++;
      end
      pool_map[cur] = UNIT_HEAD | UNIT_FREE | 6'(o);
      free_total++;
   endtask

   // compute the response of one request and update the shadow pool
   task automatic serve_request(input logic [1:0] kind, input logic [BYTES_W-1:0] size,
                                input int bidx, output grant_type g);
      logic [2:0] st;
      int at, ord, o, target, cand, co, m, bud;
      st = ST_OK; at = 0; ord = 0;
      g = '0;
      if (kind == REQ_ALLOC) begin
         carve(size, st, at, ord);
         if (st == ST_OK) used_heads.push_back(at);
      end else if (kind == REQ_FREE) begin
         if (!pool_map[bidx][5]) st = ST_NOTBLOCK;
         else if (pool_map[bidx][4]) st = ST_FREED;
         else release_block(bidx);
      end else if (kind == REQ_RESIZE) begin
         if (size == 0 || size > max_request) st = ST_BADSIZE;
         else if (!pool_map[bidx][5]) st = ST_NOTBLOCK;
         else if (pool_map[bidx][4]) st = ST_FREED;
         else begin
            o = pool_map[bidx][3:0];
            target = order_for((BYTES_W+1)'({1'b0, size} + HEADER_BYTES));
            if ({1'b0, size} + HEADER_BYTES <= (MIN_BLOCK_BYTES << o)) begin
               at = bidx; ord = o;
            end else if (target < 0) begin
               st = ST_NOSPACE;
            end else begin
               // check the buddy chain for growth in place
               cand = bidx; co = o;
               while (co < target) begin
                  bud = cand ^ (1 << co);
                  if (pool_map[bud] != (UNIT_HEAD | UNIT_FREE | 6'(co))) break;
                  if (bud < cand) cand = bud;
                  co++;
               end
               if (co >= target) begin
                  m = bidx;
                  for (co = o; co < target; co++) begin
                     bud = m ^ (1 << co);
                     pool_map[bud] = '0;
                     pool_map[m] = '0;
                     if (bud < m) m = bud;
                     free_total--;
                     block_total--;
                  end
                  pool_map[m] = UNIT_HEAD | 6'(target);
                  at = m; ord = target;
                  g.moved = (m != bidx);
               end else begin
                  carve(size, st, at, ord);
                  if (st == ST_OK || st == ST_EXT || st == ST_HUGE) begin
                     release_block(bidx);
                     g.moved = 1'b1;
                  end
               end
            end
            if (st != ST_NOSPACE) begin
               foreach (used_heads[k]) if (used_heads[k] == bidx) begin
                  used_heads.delete(k); break;
               end
               if (st == ST_OK) used_heads.push_back(at);
            end
         end
      end else begin
         st = ST_BADSIZE;
      end
      if (kind == REQ_FREE && st == ST_OK)
         foreach (used_heads[k]) if (used_heads[k] == bidx) begin
            used_heads.delete(k); break;
         end
      g.status = st;
      g.index = IDX_W'(at);
      g.order = ORD_W'(ord);
      g.free_blocks = CNT_W'(free_total);
      g.pool_blocks = CNT_W'(block_total);
   endtask

   // issue one request and hold it until accepted
   task automatic issue(input row_type r);
      grant_type g;
      @(negedge clock);
      start = 1'b1;
      req_type = r.kind;
      req_size_bytes = r.size;
      req_block_index = r.bidx;
      do @(posedge clock); while (busy);
      serve_request(r.kind, r.size, r.bidx, g);
      pending_grants.push_back(r.typed ? r.want : g);
   endtask

   task automatic pause(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // wait for all outstanding responses, then write one register
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [BYTES_W-1:0] value);
      pause(0);
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we = 1'b1;
      csr_addr = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (addr == CSR_MAX_REQ) max_request = value;
      else huge_limit = value;
   endtask

   function automatic row_type make_row(logic [1:0] kind, logic [BYTES_W-1:0] size,
                                        logic [IDX_W-1:0] bidx);
      row_type r;
      r = '0;
      r.kind = kind; r.size = size; r.bidx = bidx;
      return r;
   endfunction

   function automatic row_type make_typed(logic [1:0] kind, logic [BYTES_W-1:0] size,
                                          logic [2:0] st, int fb, int pb);
      row_type r;
      r = make_row(kind, size, '0);
      r.typed = 1'b1;
      r.want.status = st;
      r.want.free_blocks = CNT_W'(fb);
      r.want.pool_blocks = CNT_W'(pb);
      return r;
   endfunction

   // random request with mostly well-formed sizes and live block indexes
   function automatic row_type random_row();
      row_type r;
      int pick, o;
      r = '0;
      pick = $urandom_range(0, 99);
      if (pick < (used_heads.size() > 40 ? 25 : 45)) r.kind = REQ_ALLOC;
      else if (pick < 78) r.kind = REQ_FREE;
      else if (pick < 97) r.kind = REQ_RESIZE;
      else r.kind = REQ_UNKNOWN;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         o = $urandom_range(0, TOP_ORDER);
         r.size = BYTES_W'($urandom_range(1,
                  (MIN_BLOCK_BYTES << o) - (o == 0 ? HEADER_BYTES : 0)));
      end else if (pick < 86) r.size = BYTES_W'($urandom);
      else if (pick < 88) r.size = '0;
      else if (pick < 91) r.size = max_request;
      else if (pick < 94) r.size = max_request + 1'b1;
      else if (pick < 97) r.size = huge_limit;
      else r.size = '1;
      pick = $urandom_range(0, 99);
      if (pick < 80 && used_heads.size() != 0)
         r.bidx = IDX_W'(used_heads[$urandom_range(0, used_heads.size() - 1)]);
      else if (pick < 90) r.bidx = IDX_W'($urandom);
      else r.bidx = IDX_W'($urandom_range(0, TOP_BLOCKS - 1) << TOP_ORDER);
      return r;
   endfunction

   // check each response against the oldest expectation
   always @(posedge clock) begin
      grant_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_result_index, rsp_result_order, rsp_moved,
                rsp_free_blocks, rsp_pool_blocks};
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = pending_grants.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected st=%0d idx=%0d ord=%0d mv=%0b free=%0d pool=%0d",
                     want.status, want.index, want.order, want.moved, want.free_blocks,
                     want.pool_blocks);
                  $display("          got      st=%0d idx=%0d ord=%0d mv=%0b free=%0d pool=%0d",
                     got.status, got.index, got.order, got.moved, got.free_blocks,
                     got.pool_blocks);
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [BYTES_W-1:0] settings [6][2];
      int burst;
      settings = '{'{MAX_REQ_RESET, HUGE_RESET}, '{'1, '1}, '{1, 1},
                   '{5000, 2000}, '{131032, 65536}, '{'1, HUGE_RESET}};
      mismatches = 0;
      start = 1'b0; req_type = REQ_ALLOC; req_size_bytes = '0; req_block_index = '0;
      csr_we = 1'b0; csr_addr = CSR_MAX_REQ; csr_wdata = '0;
      for (int i = 0; i < POOL_UNITS; i++) pool_map[i] = '0;
      for (int b = 0; b < TOP_BLOCKS; b++)
         pool_map[b << TOP_ORDER] = UNIT_HEAD | UNIT_FREE | 6'(TOP_ORDER);
      free_total = TOP_BLOCKS;
      block_total = TOP_BLOCKS;
      max_request = MAX_REQ_RESET;
      huge_limit = HUGE_RESET;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: extremes, each request type and each corner
      directed.push_back(make_typed(REQ_ALLOC, 1, ST_OK, 41, 42));
      directed.push_back(make_typed(REQ_ALLOC, 0, ST_BADSIZE, 41, 42));
      directed.push_back(make_typed(REQ_ALLOC, '1, ST_BADSIZE, 41, 42));
      directed.push_back(make_typed(REQ_ALLOC, 4194304, ST_HUGE, 41, 42));
      directed.push_back(make_typed(REQ_ALLOC, 131033, ST_EXT, 41, 42));
      directed.push_back(make_row(REQ_ALLOC, 131032, 0));
      directed.push_back(make_row(REQ_FREE, 0, 15'h7FFF));
      directed.push_back(make_row(REQ_FREE, 0, 1));
      directed.push_back(make_row(REQ_FREE, 0, 2048));
      directed.push_back(make_row(REQ_RESIZE, 0, 0));
      directed.push_back(make_row(REQ_RESIZE, 88, 0));
      directed.push_back(make_row(REQ_RESIZE, 200, 0));
      directed.push_back(make_row(REQ_RESIZE, 5000000, 1024));
      directed.push_back(make_row(REQ_RESIZE, 131000, 0));
      directed.push_back(make_row(REQ_RESIZE, 100, 3));
      directed.push_back(make_row(REQ_RESIZE, 100, 4096));
      directed.push_back(make_row(REQ_ALLOC, 500, 0));
      directed.push_back(make_row(REQ_ALLOC, 500, 0));
      directed.push_back(make_row(REQ_RESIZE, 2000, 2056));
      directed.push_back(make_row(REQ_UNKNOWN, '1, 15'h7FFF));
      directed.push_back(make_row(REQ_FREE, 0, 0));
      directed.push_back(make_row(REQ_FREE, 0, 1024));
      directed.push_back(make_row(REQ_FREE, 0, 0));
      foreach (directed[i]) issue(directed[i]);
      used_heads.delete();
      for (int i = 0; i < POOL_UNITS; i++)
         if (pool_map[i][5] && !pool_map[i][4]) used_heads.push_back(i);

      // random traffic over several register settings
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_MAX_REQ, settings[p][0]);
         write_reg(CSR_HUGE, settings[p][1]);
         for (int n = 0; n < ITEMS_PER_PHASE; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < ITEMS_PER_PHASE; b++, n++)
               issue(random_row());
            if ($urandom_range(0, 9) < 7) pause($urandom_range(0, 6));
         end
      end

      // drain and report
      pause(0);
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (mismatches == 0 && pending_grants.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

### buddy_block_allocator_top.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_top.sv
rtl/bba_checker.sv
test/buddy_block_allocator_top_tb.sv
